>>> design/fsh_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fsh_pkg
// Shared types and constants for the frame splitter with header insertion.
// ----------------------------------------------------------------------------
package fsh_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_LARGE_BYTES = 2'd0;
  localparam logic [1:0] REG_SMALL_BYTES = 2'd1;
  localparam logic [1:0] REG_LARGE_COUNT = 2'd2;
  localparam logic [1:0] REG_SMALL_COUNT = 2'd3;

  // Widths of the configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Number of header bytes in front of each frame.
  localparam int HEADER_BYTES = 2;

  // Position of the last result within a group that opens a frame.
  localparam logic [1:0] POS_LAST_OF_THREE = 2'(HEADER_BYTES);

  // One queued result, without the per-item flags.
  typedef struct packed {
    logic [7:0] data;
    logic       hdr;
    logic       fend;
  } res_t;

endpackage : fsh_pkg
`default_nettype wire

>>> design/frame_splitter_with_header.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frame_splitter_with_header
// Cuts a byte stream into large and then small frames, putting two header
// bytes (class frame count, frame index) in front of each frame.
// ----------------------------------------------------------------------------
// An accepted item moves from the input register into the result group
// register, which presents its first result on the output port.
// Throughput: one item per cycle while out_ready is high and no frame opens;
// one result moves per cycle; a frame opener holds the port for three results.
// Reset: synchronous active-low rst_n sets the four configuration registers to
// one and clears the frame counters and all valid flags.
module frame_splitter_with_header (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // Configuration port.
  input  wire logic                          cfg_we,
  input  wire logic [fsh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [fsh_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // Input channel.
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [7:0]                    in_data_byte,
  input  wire logic                          in_buffer_end,
  // Result channel.
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [7:0]                         out_byte,
  output logic                               out_is_header,
  output logic                               out_frame_end,
  output logic                               out_length_error,
  output logic                               out_run_last
);

  // Configuration registers.
  logic [15:0] large_bytes_r;
  logic [15:0] small_bytes_r;
  logic [7:0]  large_count_r;
  logic [7:0]  small_count_r;

  // Frame tracking state.
  logic [15:0] byte_in_frame_r, byte_in_frame_nxt;
  logic [7:0]  frame_number_r, frame_number_nxt;
  logic        small_phase_r, small_phase_nxt;
  logic        all_done_r, all_done_nxt;

  // Input register.
  logic        in_v_r;
  logic [7:0]  in_data_r;
  logic        in_bend_r;

  // Result group register.
  logic                grp_v_r;
  logic                grp_three_r, grp_three_nxt;
  logic                grp_err_r, grp_err_nxt;
  logic [1:0]          pos_r;
  fsh_pkg::res_t       res_r [3];
  fsh_pkg::res_t       res_nxt [3];

  // Per-item decode signals.
  logic [15:0] lb;
  logic [7:0]  lc;
  logic        small_used;
  logic        done_eff;
  logic [15:0] fbytes;
  logic [7:0]  fcount;
  logic [7:0]  idx;
  logic        last_byte;
  logic        last_frame;
  logic        last_of_all;
  logic        err;

  // Handshake control.
  logic        grp_last;
  logic        last_take;
  logic        load_grp;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      large_bytes_r <= 16'd1;
      small_bytes_r <= 16'd1;
      large_count_r <= 8'd1;
      small_count_r <= 8'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        fsh_pkg::REG_LARGE_BYTES: large_bytes_r <= cfg_wdata;
        fsh_pkg::REG_SMALL_BYTES: small_bytes_r <= cfg_wdata;
        fsh_pkg::REG_LARGE_COUNT: large_count_r <= cfg_wdata[7:0];
        fsh_pkg::REG_SMALL_COUNT: small_count_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Handshake: the group register frees up when its last result is taken.
  assign grp_last  = grp_three_r ? (pos_r == fsh_pkg::POS_LAST_OF_THREE)
                                 : (pos_r == 2'd0);
  assign last_take = grp_v_r && out_ready && grp_last;
  assign load_grp  = in_v_r && (!grp_v_r || last_take);
  assign in_ready  = !in_v_r || load_grp;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_v_r <= 1'b1;
    end else if (load_grp) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data_byte;
      in_bend_r <= in_buffer_end;
    end
  end

  // Frame decode for the item in the input register.
  always_comb begin
    lb          = (large_bytes_r == 16'd0) ? 16'd1 : large_bytes_r;
    lc          = (large_count_r == 8'd0) ? 8'd1 : large_count_r;
    small_used  = (small_bytes_r != 16'd0) && (small_count_r != 8'd0);
    done_eff    = all_done_r || (small_phase_r && !small_used);
    fbytes      = small_phase_r ? small_bytes_r : lb;
    fcount      = small_phase_r ? small_count_r : lc;
    idx         = small_phase_r ? (lc + frame_number_r + 8'd1)
                                : (frame_number_r + 8'd1);
    last_byte   = ({1'b0, byte_in_frame_r} + 17'd1) >= {1'b0, fbytes};
    last_frame  = ({1'b0, frame_number_r} + 9'd1) >= {1'b0, fcount};
    last_of_all = last_byte && last_frame && (small_phase_r || !small_used);
    err         = in_bend_r && !last_of_all;
  end

  // Result group and next state.
  always_comb begin
    byte_in_frame_nxt = byte_in_frame_r;
    frame_number_nxt  = frame_number_r;
    small_phase_nxt   = small_phase_r;
    all_done_nxt      = all_done_r;
    grp_three_nxt     = 1'b0;
    grp_err_nxt       = err;
    res_nxt[0]        = '0;
    res_nxt[1]        = '0;
    res_nxt[2]        = '0;

    if (done_eff) begin
      // Bytes past the configured total give one zero result flagged as error.
      grp_err_nxt  = 1'b1;
      all_done_nxt = 1'b1;
    end else begin
      if (byte_in_frame_r == 16'd0) begin
        grp_three_nxt = 1'b1;
        res_nxt[0]    = '{data: fcount, hdr: 1'b1, fend: 1'b0};
        res_nxt[1]    = '{data: idx, hdr: 1'b1, fend: 1'b0};
        res_nxt[2]    = '{data: in_data_r, hdr: 1'b0, fend: last_byte || in_bend_r};
      end else begin
        res_nxt[0]    = '{data: in_data_r, hdr: 1'b0, fend: last_byte || in_bend_r};
      end

      // Advance the byte, frame and class counters.
      if (last_byte) begin
        byte_in_frame_nxt = 16'd0;
        if (last_frame) begin
          frame_number_nxt = 8'd0;
          if (small_phase_r || !small_used) begin
            small_phase_nxt = 1'b0;
            all_done_nxt    = 1'b1;
          end else begin
            small_phase_nxt = 1'b1;
          end
        end else begin
          frame_number_nxt = frame_number_r + 8'd1;
        end
      end else begin
        byte_in_frame_nxt = byte_in_frame_r + 16'd1;
      end
    end

    // The final byte of a buffer restarts everything.
    if (in_bend_r) begin
      byte_in_frame_nxt = 16'd0;
      frame_number_nxt  = 8'd0;
      small_phase_nxt   = 1'b0;
      all_done_nxt      = 1'b0;
    end
  end

  // Frame tracking state advances once per item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_in_frame_r <= 16'd0;
      frame_number_r  <= 8'd0;
      small_phase_r   <= 1'b0;
      all_done_r      <= 1'b0;
    end else if (load_grp) begin
      byte_in_frame_r <= byte_in_frame_nxt;
      frame_number_r  <= frame_number_nxt;
      small_phase_r   <= small_phase_nxt;
      all_done_r      <= all_done_nxt;
    end
  end

  // Result group control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_v_r <= 1'b0;
      pos_r   <= 2'd0;
    end else if (load_grp) begin
      grp_v_r <= 1'b1;
      pos_r   <= 2'd0;
    end else if (last_take) begin
      grp_v_r <= 1'b0;
      pos_r   <= 2'd0;
    end else if (grp_v_r && out_ready) begin
      pos_r   <= pos_r + 2'd1;
    end
  end

  // Result group payload.
  always_ff @(posedge clk) begin
    if (load_grp) begin
      grp_three_r <= grp_three_nxt;
      grp_err_r   <= grp_err_nxt;
      res_r[0]    <= res_nxt[0];
      res_r[1]    <= res_nxt[1];
      res_r[2]    <= res_nxt[2];
    end
  end

  // Result channel.
  always_comb begin
    out_valid        = grp_v_r;
    out_byte         = res_r[pos_r].data;
    out_is_header    = res_r[pos_r].hdr;
    out_frame_end    = res_r[pos_r].fend;
    out_length_error = grp_err_r;
    out_run_last     = grp_last;
  end

`ifndef NO_ASSERTIONS
  // A single-result group never leaves its first slot.
  a_single_pos: assert property (@(posedge clk) disable iff (!rst_n)
    grp_v_r && !grp_three_r |-> pos_r == 2'd0)
    else $error("single-result group moved past its first slot");

  // A header byte is never the final result of an item.
  a_hdr_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_header |-> !out_run_last)
    else $error("header byte marked as final result");

  // A buffer's last byte leaves all frame counters cleared.
  a_bend_clears: assert property (@(posedge clk) disable iff (!rst_n)
    load_grp && in_bend_r |=> byte_in_frame_r == 16'd0 && frame_number_r == 8'd0
      && !small_phase_r && !all_done_r)
    else $error("counters not cleared after buffer end");

  // The input register never drops an item waiting for the group register.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !load_grp |=> in_v_r)
    else $error("pending item lost from input register");
`endif

endmodule : frame_splitter_with_header
`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the frame splitter with header insertion. A short
// table of directed items covers reset values, size and count extremes, short
// and long buffers and register changes inside a buffer. Random buffers under
// random register settings follow. Every result is checked against a local
// model of the header and payload stream.
// ----------------------------------------------------------------------------
module tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEMS_PER_PHASE = 130;
  localparam int SHORT_ONLY_TOTAL = 300;
  localparam int MULTI_BUF_TOTAL = 40;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // One row of the directed table: an item or a full set of registers.
  typedef struct {
    row_kind_t  kind;
    logic [7:0] data;
    logic       bend;
    logic       has_lit;
    logic [7:0] lit_byte;
    logic       lit_fend;
    logic       lit_err;
    logic [15:0] lb;
    logic [15:0] sb;
    logic [7:0] lc;
    logic [7:0] sc;
  } plan_row_t;

  // One result as it leaves the block.
  typedef struct packed {
    logic [7:0] data;
    logic       hdr;
    logic       fend;
    logic       err;
    logic       last;
  } out_rec_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [fsh_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [fsh_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [7:0]                     in_data_byte = 8'h00;
  logic                           in_buffer_end = 1'b0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [7:0]                     out_byte;
  logic                           out_is_header;
  logic                           out_frame_end;
  logic                           out_length_error;
  logic                           out_run_last;

  // Local copy of the registers and the frame counters.
  logic [15:0] mdl_large_bytes;
  logic [15:0] mdl_small_bytes;
  logic [7:0]  mdl_large_count;
  logic [7:0]  mdl_small_count;
  logic [15:0] mdl_byte_in_frame;
  logic [7:0]  mdl_frame_number;
  logic        mdl_small_phase;
  logic        mdl_all_done;

  out_rec_t  pending_out_q[$];
  plan_row_t plan_q[$];
  out_rec_t  want_rec;
  out_rec_t  got_rec;
  int        fail_count = 0;
  int        cycle_count = 0;
  int        send_idle_pct = 21;
  int        recv_idle_pct = 63;

  frame_splitter_with_header i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_buffer_end    (in_buffer_end),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_is_header    (out_is_header),
    .out_frame_end    (out_frame_end),
    .out_length_error (out_length_error),
    .out_run_last     (out_run_last)
  );

  always #6 clk = ~clk;

  // Receiver stalls at random.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Run guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic void clear_counters();
    mdl_byte_in_frame = '0;
    mdl_frame_number = '0;
    mdl_small_phase = 1'b0;
    mdl_all_done = 1'b0;
  endfunction

  function automatic void push_out(input logic [7:0] d, input logic h, input logic f,
                                   input logic e, input logic l);
    pending_out_q.push_back('{data: d, hdr: h, fend: f, err: e, last: l});
  endfunction

  // Works out the results that one input byte causes and advances the counters.
  function automatic void predict_frame_bytes(input logic [7:0] d, input logic bend);
    logic [15:0] lb_eff;
    logic [7:0]  lc_eff;
    logic [15:0] fbytes;
    logic [7:0]  fcount;
    logic [7:0]  idx;
    logic        small_used;
    logic        last_b;
    logic        last_f;
    logic        last_all;
    logic        err;
    lb_eff = (mdl_large_bytes != 0) ? mdl_large_bytes : 16'd1;
    lc_eff = (mdl_large_count != 0) ? mdl_large_count : 8'd1;
    small_used = (mdl_small_bytes != 0) && (mdl_small_count != 0);
    if (mdl_small_phase && !small_used) mdl_all_done = 1'b1;

    // Every configured byte has gone out: the byte is dropped and flagged.
    if (mdl_all_done) begin
      push_out(8'h00, 1'b0, 1'b0, 1'b1, 1'b1);
      if (bend) clear_counters();
      return;
    end

    if (mdl_small_phase) begin
      fbytes = mdl_small_bytes;
      fcount = mdl_small_count;
      idx = 8'(int'(lc_eff) + int'(mdl_frame_number) + 1);
    end else begin
      fbytes = lb_eff;
      fcount = lc_eff;
      idx = 8'(int'(mdl_frame_number) + 1);
    end
    last_b = (int'(mdl_byte_in_frame) + 1) >= int'(fbytes);
    last_f = (int'(mdl_frame_number) + 1) >= int'(fcount);
    last_all = last_b && last_f && (mdl_small_phase || !small_used);
    err = bend && !last_all;

    // A frame start carries the class count and the frame index in front.
    if (mdl_byte_in_frame == 0) begin
      push_out(fcount, 1'b1, 1'b0, err, 1'b0);
      push_out(idx, 1'b1, 1'b0, err, 1'b0);
    end
    push_out(d, 1'b0, last_b || bend, err, 1'b1);

    if (bend) begin
      clear_counters();
    end else if (last_b) begin
      mdl_byte_in_frame = '0;
      if (last_f) begin
        mdl_frame_number = '0;
        if (mdl_small_phase || !small_used) begin
          mdl_small_phase = 1'b0;
          mdl_all_done = 1'b1;
        end else begin
          mdl_small_phase = 1'b1;
        end
      end else begin
        mdl_frame_number = mdl_frame_number + 8'd1;
      end
    end else begin
      mdl_byte_in_frame = mdl_byte_in_frame + 16'd1;
    end
  endfunction

  function automatic void add_item(input logic [7:0] d, input logic e);
    plan_q.push_back('{kind: ROW_ITEM, data: d, bend: e, has_lit: 1'b0, lit_byte: 8'h00,
                       lit_fend: 1'b0, lit_err: 1'b0, lb: '0, sb: '0, lc: '0, sc: '0});
  endfunction

  function automatic void add_item_lit(input logic [7:0] d, input logic e,
                                       input logic [7:0] b, input logic f,
                                       input logic er);
    plan_q.push_back('{kind: ROW_ITEM, data: d, bend: e, has_lit: 1'b1, lit_byte: b,
                       lit_fend: f, lit_err: er, lb: '0, sb: '0, lc: '0, sc: '0});
  endfunction

  function automatic void add_cfg(input logic [15:0] lb, input logic [15:0] sb,
                                  input logic [7:0] lc, input logic [7:0] sc);
    plan_q.push_back('{kind: ROW_CFG, data: 8'h00, bend: 1'b0, has_lit: 1'b0,
                       lit_byte: 8'h00, lit_fend: 1'b0, lit_err: 1'b0,
                       lb: lb, sb: sb, lc: lc, sc: sc});
  endfunction

  // Sends one item, with random gaps in front, and predicts it on acceptance.
  task automatic send_byte(input logic [7:0] d, input logic e);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= d;
    in_buffer_end <= e;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_frame_bytes(d, e);
  endtask

  // Writes one register; the caller lowers the write enable afterwards.
  task automatic write_reg(input logic [fsh_pkg::CFG_IDX_W-1:0] idx,
                           input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      fsh_pkg::REG_LARGE_BYTES: mdl_large_bytes = val;
      fsh_pkg::REG_SMALL_BYTES: mdl_small_bytes = val;
      fsh_pkg::REG_LARGE_COUNT: mdl_large_count = val[7:0];
      fsh_pkg::REG_SMALL_COUNT: mdl_small_count = val[7:0];
      default: ;
    endcase
  endtask

  // Waits until the block has drained, then writes all four registers.
  task automatic set_config(input logic [15:0] lb, input logic [15:0] sb,
                            input logic [7:0] lc, input logic [7:0] sc);
    in_valid <= 1'b0;
    while (pending_out_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    write_reg(fsh_pkg::REG_LARGE_BYTES, lb);
    write_reg(fsh_pkg::REG_SMALL_BYTES, sb);
    write_reg(fsh_pkg::REG_LARGE_COUNT, {8'h00, lc});
    write_reg(fsh_pkg::REG_SMALL_COUNT, {8'h00, sc});
    cfg_we <= 1'b0;
  endtask

  // Result checker.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got_rec = '{data: out_byte, hdr: out_is_header, fend: out_frame_end,
                  err: out_length_error, last: out_run_last};
      if (pending_out_q.size() == 0) begin
        $display("%0t: unexpected result, actual byte=%h hdr=%b fend=%b err=%b last=%b",
                 $time, got_rec.data, got_rec.hdr, got_rec.fend, got_rec.err,
                 got_rec.last);
        fail_count++;
      end else begin
        want_rec = pending_out_q.pop_front();
        if (got_rec !== want_rec) begin
          $display("%0t: mismatch, expected byte=%h hdr=%b fend=%b err=%b last=%b",
                   $time, want_rec.data, want_rec.hdr, want_rec.fend, want_rec.err,
                   want_rec.last);
          $display("%0t:           actual byte=%h hdr=%b fend=%b err=%b last=%b",
                   $time, got_rec.data, got_rec.hdr, got_rec.fend, got_rec.err,
                   got_rec.last);
          fail_count++;
        end
      end
    end
  end

  // Stimulus.
  initial begin
    plan_row_t   row;
    out_rec_t    tail;
    int          phase;
    int          phase_items;
    int          nbuf;
    int          len;
    int          total;
    int          kind;
    logic [15:0] lb;
    logic [15:0] sb;
    logic [7:0]  lc;
    logic [7:0]  sc;

    mdl_large_bytes = 16'd1;
    mdl_small_bytes = 16'd1;
    mdl_large_count = 8'd1;
    mdl_small_count = 8'd1;
    clear_counters();

    // Reset values: one large and one small frame of one byte each.
    add_item_lit(8'h00, 1'b0, 8'h00, 1'b1, 1'b0);
    add_item_lit(8'hFF, 1'b1, 8'hFF, 1'b1, 1'b0);
    add_item_lit(8'h5A, 1'b0, 8'h5A, 1'b1, 1'b0);
    add_item_lit(8'h11, 1'b0, 8'h11, 1'b1, 1'b0);
    // Long buffer: extra bytes are dropped and flagged, the end restarts.
    add_item_lit(8'h22, 1'b0, 8'h00, 1'b0, 1'b1);
    add_item_lit(8'h33, 1'b1, 8'h00, 1'b0, 1'b1);
    // Short buffer: the end arrives inside the large class.
    add_item_lit(8'hA5, 1'b1, 8'hA5, 1'b1, 1'b1);
    // Zero large size and count count as one; zero small size disables smalls.
    add_cfg(16'd0, 16'd0, 8'd0, 8'd3);
    add_item_lit(8'h80, 1'b1, 8'h80, 1'b1, 1'b0);
    // Zero small count disables smalls: two large frames of three bytes.
    add_cfg(16'd3, 16'd2, 8'd2, 8'd0);
    add_item(8'h01, 1'b0);
    add_item(8'hFE, 1'b0);
    add_item(8'h7F, 1'b0);
    add_item(8'h80, 1'b0);
    add_item(8'hC3, 1'b0);
    add_item(8'h3C, 1'b1);
    // Small class switched off during the small phase ends the buffer.
    add_cfg(16'd2, 16'd2, 8'd1, 8'd2);
    add_item(8'h10, 1'b0);
    add_item(8'h20, 1'b0);
    add_item(8'h30, 1'b0);
    add_cfg(16'd2, 16'd2, 8'd1, 8'd0);
    add_item_lit(8'h40, 1'b0, 8'h00, 1'b0, 1'b1);
    add_item_lit(8'h50, 1'b1, 8'h00, 1'b0, 1'b1);
    // Large size cut below the current position closes the frame at once.
    add_cfg(16'd4, 16'd1, 8'd1, 8'd1);
    add_item(8'h01, 1'b0);
    add_item(8'h02, 1'b0);
    add_cfg(16'd1, 16'd1, 8'd1, 8'd1);
    add_item_lit(8'h03, 1'b0, 8'h03, 1'b1, 1'b0);
    add_item_lit(8'h04, 1'b1, 8'h04, 1'b1, 1'b0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table.
    foreach (plan_q[k]) begin
      row = plan_q[k];
      if (row.kind == ROW_CFG) begin
        set_config(row.lb, row.sb, row.lc, row.sc);
      end else begin
        send_byte(row.data, row.bend);
        tail = pending_out_q[$];
        if (row.has_lit &&
            ({tail.data, tail.fend, tail.err, tail.last} !==
             {row.lit_byte, row.lit_fend, row.lit_err, 1'b1})) begin
          $display("%0t: table mismatch, expected byte=%h fend=%b err=%b",
                   $time, row.lit_byte, row.lit_fend, row.lit_err);
          $display("%0t:               predicted byte=%h fend=%b err=%b",
                   $time, tail.data, tail.fend, tail.err);
          fail_count++;
        end
      end
    end

    // Random buffers in three idle phases.
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 21;
          recv_idle_pct <= 63;
        end
        1: begin
          send_idle_pct = 63;
          recv_idle_pct <= 21;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct <= 0;
        end
      endcase
      phase_items = 0;
      while (phase_items < ITEMS_PER_PHASE) begin
        // Mostly small frames; now and then a register extreme.
        case ($urandom_range(19))
          0: begin
            lb = 16'hFFFF;
            sb = 16'($urandom_range(3));
            lc = 8'($urandom_range(1, 2));
            sc = 8'($urandom_range(3));
          end
          1: begin
            lb = 16'd1;
            sb = 16'd1;
            lc = 8'hFF;
            sc = 8'($urandom_range(1, 3));
          end
          2: begin
            lb = 16'd2;
            sb = 16'hFFFF;
            lc = 8'd1;
            sc = 8'($urandom_range(1, 2));
          end
          3: begin
            lb = 16'd1;
            sb = 16'd1;
            lc = 8'hFF;
            sc = 8'hFF;
          end
          default: begin
            lb = 16'($urandom_range(4));
            sb = 16'($urandom_range(3));
            lc = 8'($urandom_range(4));
            sc = 8'($urandom_range(3));
          end
        endcase
        set_config(lb, sb, lc, sc);
        total = ((lb != 0) ? int'(lb) : 1) * ((lc != 0) ? int'(lc) : 1) +
                ((sb != 0 && sc != 0) ? int'(sb) * int'(sc) : 0);
        // Long buffers come one at a time to keep the item count in bounds.
        nbuf = (total > MULTI_BUF_TOTAL) ? 1 : $urandom_range(1, 4);
        repeat (nbuf) begin
          kind = $urandom_range(99);
          if (total > SHORT_ONLY_TOTAL) begin
            // Huge totals: only short buffers.
            len = $urandom_range(1, 40);
            for (int j = 0; j < len; j++) send_byte(8'($urandom_range(255)), j == len - 1);
          end else if (kind < 95) begin
            if (kind < 70) len = total;
            else if (kind < 85) len = (total > 1) ? $urandom_range(1, total - 1) : 1;
            else len = total + $urandom_range(1, 3);
            for (int j = 0; j < len; j++) send_byte(8'($urandom_range(255)), j == len - 1);
          end else begin
            // Noise: stray buffer ends scattered through a few bytes.
            len = $urandom_range(1, 8);
            for (int j = 0; j < len; j++) begin
              send_byte(8'($urandom_range(255)),
                        ($urandom_range(3) == 0) || (j == len - 1));
            end
          end
          phase_items += len;
        end
      end
    end

    // Drain and let the pipeline settle.
    in_valid <= 1'b0;
    while (pending_out_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> frame_splitter_with_header.f
design/fsh_pkg.sv
design/frame_splitter_with_header.sv
bench/tb.sv
